### hw/rtl/quaternion_vector_rotate_assert.svh
// Assertion macros shared by the quaternion rotation checker.
// Needs nothing but a clock and an active-low reset in the including scope.
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Implication in the same cycle, ignored while reset is asserted.
`define QVR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, ignored while reset is asserted.
`define QVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the next cycle that is also checked through reset.
`define QVR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/qvr_pkg.sv
// Types, widths and helper functions of the quaternion vector rotation datapath.
// Used by every module of the block; depends on nothing.
package qvr_pkg;

    localparam int DW   = 16;        // width of every input and output component
    localparam int P1W  = 2 * DW;    // product of two inputs
    localparam int S1W  = P1W + 2;   // sum of three such products
    localparam int P2W  = S1W + DW;  // first-pass sum times a quaternion component
    localparam int S2W  = P2W + 2;   // sum of four such products
    localparam int FRAC = 28;        // Q2.14 times Q2.14 scale

    localparam logic signed [DW-1:0] OUT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] OUT_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef logic signed [DW-1:0]  t_comp;
    typedef logic signed [P1W-1:0] t_prod1;
    typedef logic signed [S1W-1:0] t_sum1;
    typedef logic signed [P2W-1:0] t_prod2;
    typedef logic signed [S2W-1:0] t_sum2;

    typedef struct packed {
        t_comp w;
        t_comp x;
        t_comp y;
        t_comp z;
    } t_quat;

    typedef struct packed {
        t_comp x;
        t_comp y;
        t_comp z;
    } t_vec;

    // q * v, the pure vector taken as a quaternion.
    typedef struct packed {
        t_sum1 w;
        t_sum1 x;
        t_sum1 y;
        t_sum1 z;
    } t_pquat;

    // Vector part of (q * v) * conj(q), still scaled by 2^28.
    typedef struct packed {
        t_sum2 x;
        t_sum2 y;
        t_sum2 z;
    } t_rvec;

    typedef struct packed {
        logic  clip;
        t_comp val;
    } t_sat;

    // Round to nearest with ties toward plus infinity, drop the fraction, saturate.
    function automatic t_sat round_sat(input t_sum2 v);
        t_sum2 biased;
        t_sum2 whole;
        t_sat  res;
        biased = v + (t_sum2'(1) <<< (FRAC - 1));
        whole  = biased >>> FRAC;
        if (whole > t_sum2'(OUT_MAX)) begin
            res.clip = 1'b1;
            res.val  = OUT_MAX;
        end else if (whole < t_sum2'(OUT_MIN)) begin
            res.clip = 1'b1;
            res.val  = OUT_MIN;
        end else begin
            res.clip = 1'b0;
            res.val  = whole[DW-1:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/qvr_qv_mult.sv
// First Hamilton product p = q * v: a product stage and a sum stage.
// Uses the types of qvr_pkg; passes q along for the second product.
module qvr_qv_mult (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qvr_pkg::t_quat i_quat,
    input  qvr_pkg::t_vec  i_vec,
    output logic           o_valid,
    input  logic           i_ready,
    output qvr_pkg::t_quat o_quat,
    output qvr_pkg::t_pquat o_p
);
    import qvr_pkg::*;

    logic   r_vld_a;
    logic   r_vld_b;
    logic   en_a;
    logic   en_b;

    t_quat  r_quat_a;
    t_quat  r_quat_b;
    t_pquat r_p;

    t_prod1 r_qx_vx, r_qy_vy, r_qz_vz;
    t_prod1 r_vx_w, r_vy_w, r_vz_w;
    t_prod1 r_qy_vz, r_vy_qz, r_qz_vx, r_vz_qx, r_qx_vy, r_vx_qy;

    t_pquat n_p;

    // A stage takes a new item when it is empty or its item moves on.
    assign en_b    = !r_vld_b || i_ready;
    assign en_a    = !r_vld_a || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vld_b;
    assign o_quat  = r_quat_b;
    assign o_p     = r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (en_a) r_vld_a <= i_valid;
            if (en_b) r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_quat_a <= i_quat;
            r_qx_vx  <= t_prod1'(i_quat.x) * t_prod1'(i_vec.x);
            r_qy_vy  <= t_prod1'(i_quat.y) * t_prod1'(i_vec.y);
            r_qz_vz  <= t_prod1'(i_quat.z) * t_prod1'(i_vec.z);
            r_vx_w   <= t_prod1'(i_vec.x) * t_prod1'(i_quat.w);
            r_vy_w   <= t_prod1'(i_vec.y) * t_prod1'(i_quat.w);
            r_vz_w   <= t_prod1'(i_vec.z) * t_prod1'(i_quat.w);
            r_qy_vz  <= t_prod1'(i_quat.y) * t_prod1'(i_vec.z);
            r_vy_qz  <= t_prod1'(i_vec.y) * t_prod1'(i_quat.z);
            r_qz_vx  <= t_prod1'(i_quat.z) * t_prod1'(i_vec.x);
            r_vz_qx  <= t_prod1'(i_vec.z) * t_prod1'(i_quat.x);
            r_qx_vy  <= t_prod1'(i_quat.x) * t_prod1'(i_vec.y);
            r_vx_qy  <= t_prod1'(i_vec.x) * t_prod1'(i_quat.y);
        end
        if (en_b && r_vld_a) begin
            r_quat_b <= r_quat_a;
            r_p      <= n_p;
        end
    end

    // The scalar part is minus the dot product; the vector part adds the cross product.
    always_comb begin
        n_p.w = t_sum1'(0) - t_sum1'(r_qx_vx) - t_sum1'(r_qy_vy) - t_sum1'(r_qz_vz);
        n_p.x = t_sum1'(r_vx_w) + t_sum1'(r_qy_vz) - t_sum1'(r_vy_qz);
        n_p.y = t_sum1'(r_vy_w) + t_sum1'(r_qz_vx) - t_sum1'(r_vz_qx);
        n_p.z = t_sum1'(r_vz_w) + t_sum1'(r_qx_vy) - t_sum1'(r_vx_qy);
    end

endmodule

### hw/rtl/qvr_pq_mult.sv
// Second Hamilton product r = p * conj(q), vector part only: product and sum stages.
// Uses the types of qvr_pkg; fed by qvr_qv_mult.
module qvr_pq_mult (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qvr_pkg::t_quat  i_quat,
    input  qvr_pkg::t_pquat i_p,
    output logic            o_valid,
    input  logic            i_ready,
    output qvr_pkg::t_rvec  o_r
);
    import qvr_pkg::*;

    logic   r_vld_a;
    logic   r_vld_b;
    logic   en_a;
    logic   en_b;

    t_prod2 r_px_w, r_py_w, r_pz_w;
    t_prod2 r_pw_qx, r_pw_qy, r_pw_qz;
    t_prod2 r_py_qz, r_qy_pz, r_pz_qx, r_qz_px, r_px_qy, r_qx_py;

    t_rvec  r_r;
    t_rvec  n_r;

    assign en_b    = !r_vld_b || i_ready;
    assign en_a    = !r_vld_a || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vld_b;
    assign o_r     = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (en_a) r_vld_a <= i_valid;
            if (en_b) r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_px_w  <= t_prod2'(i_p.x) * t_prod2'(i_quat.w);
            r_py_w  <= t_prod2'(i_p.y) * t_prod2'(i_quat.w);
            r_pz_w  <= t_prod2'(i_p.z) * t_prod2'(i_quat.w);
            r_pw_qx <= t_prod2'(i_p.w) * t_prod2'(i_quat.x);
            r_pw_qy <= t_prod2'(i_p.w) * t_prod2'(i_quat.y);
            r_pw_qz <= t_prod2'(i_p.w) * t_prod2'(i_quat.z);
            r_py_qz <= t_prod2'(i_p.y) * t_prod2'(i_quat.z);
            r_qy_pz <= t_prod2'(i_quat.y) * t_prod2'(i_p.z);
            r_pz_qx <= t_prod2'(i_p.z) * t_prod2'(i_quat.x);
            r_qz_px <= t_prod2'(i_quat.z) * t_prod2'(i_p.x);
            r_px_qy <= t_prod2'(i_p.x) * t_prod2'(i_quat.y);
            r_qx_py <= t_prod2'(i_quat.x) * t_prod2'(i_p.y);
        end
        if (en_b && r_vld_a) begin
            r_r <= n_r;
        end
    end

    // The conjugate negates the vector part of q, which flips the sign of
    // every term that carries one of its components.
    always_comb begin
        n_r.x = t_sum2'(r_px_w) - t_sum2'(r_pw_qx) - t_sum2'(r_py_qz) + t_sum2'(r_qy_pz);
        n_r.y = t_sum2'(r_py_w) - t_sum2'(r_pw_qy) - t_sum2'(r_pz_qx) + t_sum2'(r_qz_px);
        n_r.z = t_sum2'(r_pz_w) - t_sum2'(r_pw_qz) - t_sum2'(r_px_qy) + t_sum2'(r_qx_py);
    end

endmodule

### hw/rtl/qvr_round_sat.sv
// Output stage: rounds the 2^28-scaled components, saturates them and flags clipping.
// Uses round_sat and the types of qvr_pkg; holds the result register of the block.
module qvr_round_sat (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  qvr_pkg::t_rvec         i_r,
    output logic                   o_valid,
    input  logic                   i_ready,
    output qvr_pkg::t_comp         o_rot_x,
    output qvr_pkg::t_comp         o_rot_y,
    output qvr_pkg::t_comp         o_rot_z,
    output logic                   o_clipped
);
    import qvr_pkg::*;

    logic  r_vld;
    logic  en;
    t_sat  sat_x, sat_y, sat_z;
    t_comp r_rot_x, r_rot_y, r_rot_z;
    logic  r_clipped;

    assign en      = !r_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld;

    assign sat_x = round_sat(i_r.x);
    assign sat_y = round_sat(i_r.y);
    assign sat_z = round_sat(i_r.z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_rot_x   <= sat_x.val;
            r_rot_y   <= sat_y.val;
            r_rot_z   <= sat_z.val;
            r_clipped <= sat_x.clip | sat_y.clip | sat_z.clip;
        end
    end

    assign o_rot_x   = r_rot_x;
    assign o_rot_y   = r_rot_y;
    assign o_rot_z   = r_rot_z;
    assign o_clipped = r_clipped;

endmodule

### hw/rtl/quaternion_vector_rotate.sv
// Rotates a 3-vector by a Q2.14 quaternion as q * v * conj(q), without normalizing q, so a
// non-unit q also scales the vector by |q|^2. The block takes one item per clock while the output
// is not stalled, and holds each item in five register stages: two multiply stages, each followed
// by an adder stage, and a round-and-saturate output register. Every stage holds its item
// independently, so a stalled output only backs up the stages behind it and input is taken
// while any stage is free. Halfway cases round toward plus infinity; o_clipped marks a
// result where any component was held at the 16-bit limits.
module quaternion_vector_rotate (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_quat_w,
    input  logic signed [15:0]    i_quat_x,
    input  logic signed [15:0]    i_quat_y,
    input  logic signed [15:0]    i_quat_z,
    input  logic signed [15:0]    i_vec_x,
    input  logic signed [15:0]    i_vec_y,
    input  logic signed [15:0]    i_vec_z,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [15:0]    o_rot_x,
    output logic signed [15:0]    o_rot_y,
    output logic signed [15:0]    o_rot_z,
    output logic                  o_clipped
);
    import qvr_pkg::*;

    t_quat  in_quat;
    t_vec   in_vec;

    logic   qv_valid;
    logic   qv_ready;
    t_quat  qv_quat;
    t_pquat qv_p;

    logic   pq_valid;
    logic   pq_ready;
    t_rvec  pq_r;

    assign in_quat = '{w: i_quat_w, x: i_quat_x, y: i_quat_y, z: i_quat_z};
    assign in_vec  = '{x: i_vec_x, y: i_vec_y, z: i_vec_z};

    qvr_qv_mult u_qv_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_quat  (in_quat),
        .i_vec   (in_vec),
        .o_valid (qv_valid),
        .i_ready (qv_ready),
        .o_quat  (qv_quat),
        .o_p     (qv_p)
    );

    qvr_pq_mult u_pq_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (qv_valid),
        .o_ready (qv_ready),
        .i_quat  (qv_quat),
        .i_p     (qv_p),
        .o_valid (pq_valid),
        .i_ready (pq_ready),
        .o_r     (pq_r)
    );

    qvr_round_sat u_round_sat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (pq_valid),
        .o_ready   (pq_ready),
        .i_r       (pq_r),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rot_x   (o_rot_x),
        .o_rot_y   (o_rot_y),
        .o_rot_z   (o_rot_z),
        .o_clipped (o_clipped)
    );

endmodule

### hw/rtl/qvr_checker.sv
// Port-level checks of the quaternion rotation block, bound to its top level.
// Depends on the macros of quaternion_vector_rotate_assert.svh.
`include "quaternion_vector_rotate_assert.svh"

module qvr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic signed [15:0] i_quat_w,
    input logic signed [15:0] i_quat_x,
    input logic signed [15:0] i_quat_y,
    input logic signed [15:0] i_quat_z,
    input logic signed [15:0] i_vec_x,
    input logic signed [15:0] i_vec_y,
    input logic signed [15:0] i_vec_z,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_rot_x,
    input logic signed [15:0] o_rot_y,
    input logic signed [15:0] o_rot_z,
    input logic               o_clipped
);
    import qvr_pkg::*;

    logic at_limit;
    logic in_unused;

    assign at_limit = (o_rot_x == OUT_MAX) || (o_rot_x == OUT_MIN)
                   || (o_rot_y == OUT_MAX) || (o_rot_y == OUT_MIN)
                   || (o_rot_z == OUT_MAX) || (o_rot_z == OUT_MIN);

    // The input payload is only watched through the handshake here.
    assign in_unused = i_valid ^ (^{i_quat_w, i_quat_x, i_quat_y, i_quat_z,
                                    i_vec_x, i_vec_y, i_vec_z});

    // A result that waits keeps its value until it is taken.
    `QVR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable({o_rot_x, o_rot_y, o_rot_z, o_clipped}), "result changed while stalled")

    // A clipped result must show at least one component at a limit.
    `QVR_ASSERT_NOW(a_clip_limit, i_clk, i_rst_n, o_valid && o_clipped, at_limit, "clip flag without a saturated component")

    // With the output free to move, no stage can hold back a new item.
    `QVR_ASSERT_NOW(a_flow, i_clk, i_rst_n, !o_valid || i_ready, o_ready, "input stalled though output is free")

    // Reset empties the pipeline at once.
    `QVR_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid || in_unused !== in_unused, "result valid right after reset")

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);
